### rtl/core/assert_macros.svh
// Assertion macros for the RTL of the line substring matcher.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Plain property, checked on every rising edge outside reset.
`define LSM_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("lsm assertion failed");

// Same-cycle implication.
`define LSM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lsm implication failed");

// Next-cycle implication.
`define LSM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lsm next-cycle implication failed");

`else

`define LSM_ASSERT(lbl, clk, rst_n, prop)
`define LSM_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define LSM_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

### rtl/core/lsm_pkg.sv
// Shared types, constants and helpers of the line substring matcher.
`timescale 1ns / 1ps

package lsm_pkg;

	localparam int PAT_MAX    = 16;
	localparam int PLEN_W     = $clog2(PAT_MAX + 1);
	localparam int PIDX_W     = $clog2(PAT_MAX);
	localparam int LINE_MAX   = 8192;
	localparam int LEN_W      = $clog2(LINE_MAX);
	localparam int FIFO_DEPTH = 4;
	localparam int FPTR_W     = $clog2(FIFO_DEPTH);
	localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

	localparam logic [7:0] NEWLINE_BYTE = 8'h0A;
	localparam logic [7:0] CHAR_A       = 8'h41;
	localparam logic [7:0] CHAR_Z       = 8'h5A;
	localparam logic [7:0] CASE_GAP     = 8'd32;
	localparam logic [7:0] NUL_BYTE     = 8'h00;
	localparam logic [31:0] COUNT_TOP   = 32'hFFFF_FFFF;

	localparam logic MODE_BYTE = 1'b0;
	localparam logic MODE_EOF  = 1'b1;
	localparam logic KIND_LINE = 1'b0;
	localparam logic KIND_FILE = 1'b1;

	localparam logic [2:0] CFG_PAT_LO = 3'd0;
	localparam logic [2:0] CFG_PAT_HI = 3'd1;
	localparam logic [2:0] CFG_PAT_LEN = 3'd2;
	localparam logic [2:0] CFG_FOLD   = 3'd3;
	localparam logic [2:0] CFG_INVERT = 3'd4;

	typedef struct packed {
		logic        kind;
		logic        selected;
		logic [31:0] line_number;
		logic [31:0] file_hits;
		logic [31:0] total_hits;
		logic        last;
	} res_t;

	typedef struct packed {
		logic shift;
		logic clear;
		logic fold;
	} cell_ctl_t;

	function automatic logic [7:0] fold_byte(input logic [7:0] b, input logic fold);
		if (fold && b >= CHAR_A && b <= CHAR_Z) begin
			return b + CASE_GAP;
		end
		return b;
	endfunction

endpackage

### rtl/core/lsm_cell.sv
// One window cell: holds a recent text byte and checks it against its pattern byte.
`timescale 1ns / 1ps

module lsm_cell
	import lsm_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cell_ctl_t  ctl,
	input  logic [7:0] din,
	input  logic [7:0] pat,
	input  logic       en,
	output logic [7:0] dout,
	output logic       hit
);

	logic [7:0] byte_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q <= NUL_BYTE;
		end else if (ctl.clear) begin
			byte_q <= NUL_BYTE;
		end else if (ctl.shift) begin
			byte_q <= din;
		end
	end

	assign dout = byte_q;
	// positions beyond the pattern always agree
	assign hit  = !en || (fold_byte(byte_q, ctl.fold) == fold_byte(pat, ctl.fold));

endmodule

### rtl/core/lsm_out_fifo.sv
// Four-word result queue; takes up to two words per cycle, gives one.
`timescale 1ns / 1ps

module lsm_out_fifo
	import lsm_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push0,
	input  res_t word0,
	input  logic push1,
	input  res_t word1,
	output logic room2,
	output logic out_valid,
	input  logic out_ready,
	output res_t head
);

	res_t              mem_q [FIFO_DEPTH];
	logic [FPTR_W-1:0] wr_ptr_q;
	logic [FPTR_W-1:0] rd_ptr_q;
	logic [FCNT_W-1:0] cnt_q;
	logic              pop;
	logic [FPTR_W-1:0] wr_ptr1;

	assign pop     = out_valid && out_ready;
	assign wr_ptr1 = wr_ptr_q + FPTR_W'(1);

	always_ff @(posedge clk) begin
		if (push0) begin
			mem_q[wr_ptr_q] <= word0;
		end
		if (push1) begin
			mem_q[wr_ptr1] <= word1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + FPTR_W'(push0) + FPTR_W'(push1);
			rd_ptr_q <= rd_ptr_q + FPTR_W'(pop);
			cnt_q    <= cnt_q + FCNT_W'(push0) + FCNT_W'(push1) - FCNT_W'(pop);
		end
	end

	assign room2     = cnt_q <= FCNT_W'(FIFO_DEPTH - 2);
	assign out_valid = cnt_q != '0;
	assign head      = mem_q[rd_ptr_q];

endmodule

### rtl/core/line_substring_matcher_top.sv
// Top level of the line substring matcher: config, line state, window cells, result queue.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Streams file bytes, one word per cycle, and reports per line whether the
// configured pattern (up to 16 bytes, optional ASCII case folding and inverted
// selection) occurs in it. A byte is decided in the cycle it is accepted: a row
// of 15 window cells plus a head comparator checks the whole pattern at once.
// A newline gives one line word; end of file gives a summary word, preceded by
// a line word when a partial line is pending. Result words leave through a
// four-word queue at one per cycle; in_ready drops while fewer than two slots
// are free, so sustained input is one byte per cycle as long as out_ready
// stays high. No clearing pass after reset. Configuration may only be written
// while no result is outstanding.
module line_substring_matcher_top
	import lsm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        mode,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        kind,
	output logic        selected,
	output logic [31:0] line_number,
	output logic [31:0] file_hits,
	output logic [31:0] total_hits,
	output logic        last
);

	logic [63:0]       pat_lo_q;
	logic [63:0]       pat_hi_q;
	logic [4:0]        pat_len_q;
	logic              fold_q;
	logic              inv_q;

	logic [LEN_W-1:0]  line_len_q;
	logic              cut_q;
	logic              found_q;
	logic [31:0]       line_cnt_q;
	logic [31:0]       fh_q;
	logic [31:0]       tot_q;

	logic [7:0]        pat_bytes [PAT_MAX];
	logic [7:0]        aln [PAT_MAX];
	logic [PAT_MAX-1:0] pos_en;
	logic [PLEN_W-1:0] len_clip;
	logic [PLEN_W-1:0] eff_len;
	logic [PLEN_W-1:0] idx;

	logic [7:0]        chain_in [PAT_MAX-1];
	logic [7:0]        cell_q [PAT_MAX-1];
	logic [PAT_MAX-2:0] cell_hit;
	logic              head_hit;
	logic              match;
	cell_ctl_t         cctl;

	logic              in_fire;
	logic              is_nl;
	logic              is_eof;
	logic              flush;
	logic              take;
	logic              sel;
	logic [31:0]       cnt_next;
	logic [31:0]       fh_next;
	logic [31:0]       tot_next;
	logic [31:0]       sum_cnt;
	logic [31:0]       sum_fh;
	logic [31:0]       sum_tot;
	res_t              word0;
	res_t              word1;
	logic              push0;
	logic              push1;
	res_t              head;

	function automatic logic [31:0] sat_inc(input logic [31:0] v);
		return (v == COUNT_TOP) ? v : v + 32'd1;
	endfunction

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_lo_q  <= '0;
			pat_hi_q  <= '0;
			pat_len_q <= '0;
			fold_q    <= 1'b0;
			inv_q     <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_PAT_LO:  pat_lo_q  <= cfg_data;
				CFG_PAT_HI:  pat_hi_q  <= cfg_data;
				CFG_PAT_LEN: pat_len_q <= cfg_data[4:0];
				CFG_FOLD:    fold_q    <= cfg_data[0];
				CFG_INVERT:  inv_q     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// effective pattern and its alignment to the window
	always_comb begin
		for (int i = 0; i < PAT_MAX; i++) begin
			pat_bytes[i] = (i < 8) ? pat_lo_q[8*(i%8) +: 8] : pat_hi_q[8*(i%8) +: 8];
		end
		len_clip = (pat_len_q > 5'(PAT_MAX)) ? PLEN_W'(PAT_MAX) : PLEN_W'(pat_len_q);
		eff_len  = len_clip;
		for (int i = PAT_MAX - 1; i >= 0; i--) begin
			if (PLEN_W'(i) < len_clip && pat_bytes[i] == NUL_BYTE) begin
				eff_len = PLEN_W'(i);
			end
		end
		idx = '0;
		for (int j = 0; j < PAT_MAX; j++) begin
			pos_en[j] = PLEN_W'(j) < eff_len;
			idx       = eff_len - PLEN_W'(1) - PLEN_W'(j);
			aln[j]    = pat_bytes[idx[PIDX_W-1:0]];
		end
	end

	assign in_fire = in_valid && in_ready;
	assign is_eof  = mode == MODE_EOF;
	assign is_nl   = !is_eof && data_byte == NEWLINE_BYTE;
	assign flush   = is_nl || (is_eof && line_len_q != '0);
	assign take    = in_fire && !is_eof && !is_nl && line_len_q < LEN_W'(LINE_MAX - 1);

	assign cctl.clear = in_fire && (is_nl || is_eof);
	assign cctl.shift = take && !cut_q && data_byte != NUL_BYTE;
	assign cctl.fold  = fold_q;

	always_comb begin
		chain_in[0] = data_byte;
		for (int k = 1; k < PAT_MAX - 1; k++) begin
			chain_in[k] = cell_q[k-1];
		end
	end

	for (genvar k = 0; k < PAT_MAX - 1; k++) begin : g_cell
		lsm_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (cctl),
			.din    (chain_in[k]),
			.pat    (aln[k+1]),
			.en     (pos_en[k+1]),
			.dout   (cell_q[k]),
			.hit    (cell_hit[k])
		);
	end

	assign head_hit = !pos_en[0] ||
		(fold_byte(data_byte, fold_q) == fold_byte(aln[0], fold_q));
	assign match    = head_hit && (&cell_hit);

	// verdict and summary words
	always_comb begin
		sel      = found_q ^ inv_q;
		cnt_next = sat_inc(line_cnt_q);
		fh_next  = sel ? sat_inc(fh_q) : fh_q;
		tot_next = sel ? sat_inc(tot_q) : tot_q;
		sum_cnt  = flush ? cnt_next : line_cnt_q;
		sum_fh   = flush ? fh_next : fh_q;
		sum_tot  = flush ? tot_next : tot_q;

		word1.kind        = KIND_FILE;
		word1.selected    = sum_fh != '0;
		word1.line_number = sum_cnt;
		word1.file_hits   = sum_fh;
		word1.total_hits  = sum_tot;
		word1.last        = 1'b1;

		if (flush) begin
			word0.kind        = KIND_LINE;
			word0.selected    = sel;
			word0.line_number = cnt_next;
			word0.file_hits   = fh_next;
			word0.total_hits  = tot_next;
			word0.last        = !is_eof;
		end else begin
			word0 = word1;
		end
	end

	assign push0 = in_fire && (is_nl || is_eof);
	assign push1 = in_fire && is_eof && line_len_q != '0;

	// line and counter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_len_q <= '0;
			cut_q      <= 1'b0;
			found_q    <= 1'b0;
			line_cnt_q <= '0;
			fh_q       <= '0;
			tot_q      <= '0;
		end else if (cctl.clear) begin
			line_len_q <= '0;
			cut_q      <= 1'b0;
			found_q    <= 1'b0;
			line_cnt_q <= is_eof ? '0 : cnt_next;
			fh_q       <= is_eof ? '0 : fh_next;
			tot_q      <= flush ? tot_next : tot_q;
		end else if (take) begin
			line_len_q <= line_len_q + LEN_W'(1);
			if (!cut_q) begin
				if (data_byte == NUL_BYTE) begin
					cut_q <= 1'b1;
				end else if (match) begin
					found_q <= 1'b1;
				end
			end
		end
	end

	lsm_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push0     (push0),
		.word0     (word0),
		.push1     (push1),
		.word1     (word1),
		.room2     (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.head      (head)
	);

	assign kind        = head.kind;
	assign selected    = head.selected;
	assign line_number = head.line_number;
	assign file_hits   = head.file_hits;
	assign total_hits  = head.total_hits;
	assign last        = head.last;

	`LSM_ASSERT_IMP(a_stall_has_words, clk, arst_n, !in_ready, out_valid)
	`LSM_ASSERT_NXT(a_eof_gives_word, clk, arst_n, in_fire && is_eof, out_valid)
	`LSM_ASSERT(a_line_len_bound, clk, arst_n, line_len_q <= LEN_W'(LINE_MAX - 1))
	`LSM_ASSERT_IMP(a_hits_le_lines, clk, arst_n, out_valid, file_hits <= line_number)

endmodule
